@@ rtl/aes256_cbc_encrypt_top_macros.svh @@
// assertion macros for the aes-256 cbc encryption block
// used by aes256_cbc_encrypt_top; no other dependencies
`ifndef AES256_CBC_ENCRYPT_TOP_MACROS_SVH
`define AES256_CBC_ENCRYPT_TOP_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/aes_cbc_pkg.sv @@
// types, constants and round functions for the aes-256 cbc encryption block
// no dependencies
`timescale 1ns / 1ps
package aes_cbc_pkg;
    localparam int RK_WORDS = 60;
    localparam int NUM_ROUNDS = 14;

    localparam logic [2:0] REG_KEY_W0 = 3'd0;
    localparam logic [2:0] REG_KEY_W1 = 3'd1;
    localparam logic [2:0] REG_KEY_W2 = 3'd2;
    localparam logic [2:0] REG_KEY_W3 = 3'd3;
    localparam logic [2:0] REG_IV_UPPER = 3'd4;
    localparam logic [2:0] REG_IV_LOWER = 3'd5;

    typedef struct packed {
        logic [63:0] pt_upper;
        logic [63:0] pt_lower;
        logic        first_block;
        logic        last_block;
    } pt_item_t;

    typedef struct packed {
        logic [63:0] ct_upper;
        logic [63:0] ct_lower;
        logic        ct_last;
    } ct_item_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // byte i of the state sits at bits 127-8i
    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8 * (4 * c + r) -: 8] = SBOX[s[127 - 8 * (4 * ((c + r) % 4) + r) -: 8]];
            end
        end
        sub_shift = t;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0] a0, a1, a2, a3, all;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            a0 = s[127 - 32 * c -: 8];
            a1 = s[119 - 32 * c -: 8];
            a2 = s[111 - 32 * c -: 8];
            a3 = s[103 - 32 * c -: 8];
            all = a0 ^ a1 ^ a2 ^ a3;
            t[127 - 32 * c -: 32] = {a0 ^ all ^ xtime(a0 ^ a1), a1 ^ all ^ xtime(a1 ^ a2),
                                     a2 ^ all ^ xtime(a2 ^ a3), a3 ^ all ^ xtime(a3 ^ a0)};
        end
        mix_columns = t;
    endfunction
endpackage

@@ rtl/aes256_cbc_encrypt_top.sv @@
// aes-256 cbc encryption block: apb registers, key expansion sequencer, round unit
// depends on aes_cbc_pkg and aes256_cbc_encrypt_top_macros.svh
//
// usage: write the four key words and the two iv words over the apb port while idle.
// plaintext blocks enter on in_valid / in_stall, one transfer per block; first_block
// selects the iv as chaining value, else the previous ciphertext is used.
// ciphertext leaves on out_valid / out_stall with ct_last copied from last_block.
// each block goes through the load and then 14 rounds of the one round unit before
// out_valid rises; after reset or a key write the first block first runs key
// expansion, one round-key word per cycle through the sub_word path.
// a new block is taken only after the previous one leaves the round unit; the output
// register lets the next block start while the previous result waits to be taken.
// a stalled receiver holds the output register; a block that finishes meanwhile
// waits in the round unit and in_stall stays high until it moves on.
// reset clears the registers, the chaining value and the expanded flag; the
// round-key memory is not cleared, it is always written before it is read.
`timescale 1ns / 1ps
`include "aes256_cbc_encrypt_top_macros.svh"
module aes256_cbc_encrypt_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [5:0]            paddr,
    input  logic [63:0]           pwdata,
    output logic [63:0]           prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  aes_cbc_pkg::pt_item_t in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output aes_cbc_pkg::ct_item_t out_data
);
    import aes_cbc_pkg::*;

    localparam int RKW = $clog2(RK_WORDS);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXP = 3'd1;
    localparam logic [2:0] ST_RND = 3'd2;
    localparam logic [2:0] ST_OUT = 3'd3;

    logic [63:0] key_reg [4];
    logic [63:0] iv_up_reg, iv_lo_reg;
    logic [127:0] chain_reg;
    logic expanded_reg;
    logic [2:0] state_reg, state_next;
    logic [RKW-1:0] idx_reg;
    logic [3:0] rnd_reg;
    logic [127:0] st_reg;
    logic last_reg;
    logic [127:0] rk_mem [NUM_ROUNDS + 1];
    logic [31:0] w1_reg [8];
    logic [127:0] rk_block;
    logic [31:0] exp_word;
    logic [7:0] rcon_val;
    logic [127:0] rnd_out;
    logic [127:0] fin_block;
    logic out_valid_reg;
    ct_item_t ct_out_reg;
    logic wr_en, key_wr, in_acc;
    logic rnd_last, out_free, out_load;
    logic [2:0] reg_idx;

    assign pready = 1'b1;
    assign reg_idx = paddr[5:3];
    assign wr_en = psel && penable && pwrite;
    assign key_wr = wr_en && (reg_idx == REG_KEY_W0 || reg_idx == REG_KEY_W1 ||
                              reg_idx == REG_KEY_W2 || reg_idx == REG_KEY_W3);
    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data = ct_out_reg;
    assign rnd_last = (state_reg == ST_RND) && (rnd_reg == 4'(NUM_ROUNDS + 1));
    assign out_free = !out_valid_reg || !out_stall;
    assign out_load = out_free && (rnd_last || state_reg == ST_OUT);
    assign fin_block = (state_reg == ST_OUT) ? st_reg : (rnd_out ^ rk_block);

    always_comb
    begin
        case (reg_idx)
            REG_KEY_W0: prdata = key_reg[0];
            REG_KEY_W1: prdata = key_reg[1];
            REG_KEY_W2: prdata = key_reg[2];
            REG_KEY_W3: prdata = key_reg[3];
            REG_IV_UPPER: prdata = iv_up_reg;
            REG_IV_LOWER: prdata = iv_lo_reg;
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                key_reg[i] <= '0;
            end
            iv_up_reg <= '0;
            iv_lo_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_KEY_W0: key_reg[0] <= pwdata;
                REG_KEY_W1: key_reg[1] <= pwdata;
                REG_KEY_W2: key_reg[2] <= pwdata;
                REG_KEY_W3: key_reg[3] <= pwdata;
                REG_IV_UPPER: iv_up_reg <= pwdata;
                REG_IV_LOWER: iv_lo_reg <= pwdata;
                default: ;
            endcase
        end
    end

    // key expansion: window of the last eight words in w1_reg
    always_comb
    begin
        case (idx_reg[RKW-1:3])
            3'd1: rcon_val = 8'h01;
            3'd2: rcon_val = 8'h02;
            3'd3: rcon_val = 8'h04;
            3'd4: rcon_val = 8'h08;
            3'd5: rcon_val = 8'h10;
            3'd6: rcon_val = 8'h20;
            3'd7: rcon_val = 8'h40;
            default: rcon_val = 8'h00;
        endcase
        if (idx_reg[2:0] == 3'd0)
        begin
            exp_word = w1_reg[0] ^ sub_word({w1_reg[7][23:0], w1_reg[7][31:24]})
                       ^ {rcon_val, 24'h0};
        end
        else if (idx_reg[2:0] == 3'd4)
        begin
            exp_word = w1_reg[0] ^ sub_word(w1_reg[7]);
        end
        else
        begin
            exp_word = w1_reg[0] ^ w1_reg[7];
        end
    end

    // round-key memory: one round key per entry, filled four words at a time
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EXP)
        begin
            if (idx_reg[1:0] == 2'd3)
            begin
                rk_mem[idx_reg[RKW-1:2]] <= {w1_reg[5], w1_reg[6], w1_reg[7], exp_word};
            end
        end
        else if (in_acc && !expanded_reg)
        begin
            rk_mem[0] <= {key_reg[0], key_reg[1]};
            rk_mem[1] <= {key_reg[2], key_reg[3]};
        end
        if (rnd_reg != 4'(NUM_ROUNDS + 1))
        begin
            rk_block <= rk_mem[rnd_reg];
        end
    end

    always_comb
    begin
        if (rnd_reg == 4'(NUM_ROUNDS + 1))
        begin
            rnd_out = sub_shift(st_reg);
        end
        else
        begin
            rnd_out = mix_columns(sub_shift(st_reg));
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = expanded_reg ? ST_RND : ST_EXP;
                end
            end
            ST_EXP:
            begin
                if (idx_reg == RKW'(RK_WORDS - 1))
                begin
                    state_next = ST_RND;
                end
            end
            ST_RND:
            begin
                if (rnd_reg == 4'(NUM_ROUNDS + 1))
                begin
                    state_next = out_free ? ST_IDLE : ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // rnd_reg leads the state by one: rk_block holds the key for rnd_reg - 1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            expanded_reg <= 1'b0;
            chain_reg <= '0;
            idx_reg <= '0;
            rnd_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (key_wr)
            begin
                expanded_reg <= 1'b0;
            end
            else if (state_reg == ST_EXP && idx_reg == RKW'(RK_WORDS - 1))
            begin
                expanded_reg <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                chain_reg <= fin_block;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    idx_reg <= RKW'(8);
                    rnd_reg <= (in_acc && expanded_reg) ? 4'd1 : 4'd0;
                end
                ST_EXP:
                begin
                    idx_reg <= idx_reg + RKW'(1);
                    if (idx_reg == RKW'(RK_WORDS - 1))
                    begin
                        rnd_reg <= 4'd1;
                    end
                end
                ST_RND:
                begin
                    rnd_reg <= rnd_reg + 4'd1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            ct_out_reg <= '{ct_upper: fin_block[127:64], ct_lower: fin_block[63:0],
                            ct_last: last_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            st_reg <= {in_data.pt_upper, in_data.pt_lower} ^
                      (in_data.first_block ? {iv_up_reg, iv_lo_reg} : chain_reg);
            last_reg <= in_data.last_block;
            for (int i = 0; i < 8; i++)
            begin
                w1_reg[i] <= key_reg[i / 2][63 - 32 * (i % 2) -: 32];
            end
        end
        else if (state_reg == ST_EXP)
        begin
            for (int i = 0; i < 7; i++)
            begin
                w1_reg[i] <= w1_reg[i + 1];
            end
            w1_reg[7] <= exp_word;
        end
        else if (state_reg == ST_RND)
        begin
            if (rnd_reg == 4'd1)
            begin
                st_reg <= st_reg ^ rk_block;
            end
            else
            begin
                st_reg <= rnd_out ^ rk_block;
            end
        end
    end

    `ASSERT_IMPL(a_idle_ready, clk, rst_n, state_reg == ST_IDLE, !in_stall)
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
    `ASSERT_NEXT(a_exp_flag, clk, rst_n, state_reg == ST_RND && !key_wr, expanded_reg)
    `ASSERT_IMPL(a_rnd_range, clk, rst_n, state_reg == ST_RND, rnd_reg != 4'd0)
endmodule

@@ verif/aes256_cbc_checker.sv @@
// checker for the aes-256 cbc encryption block: tracks apb writes, predicts ciphertext
// depends on aes_cbc_pkg for the transfer types, register indexes and the s-box table
`timescale 1ns / 1ps
module aes256_cbc_checker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [5:0]            paddr,
    input  logic [63:0]           pwdata,
    input  logic                  pready,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  aes_cbc_pkg::pt_item_t in_data,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  aes_cbc_pkg::ct_item_t out_data,
    output int                    errors,
    output int                    pending,
    output int                    accepted
);
    import aes_cbc_pkg::*;

    logic [63:0] key_word [4];
    logic [63:0] iv_hi, iv_lo;
    logic [63:0] chain_hi, chain_lo;
    logic [31:0] round_key [RK_WORDS];
    logic        keys_stale;
    ct_item_t    ct_expected [$];

    function automatic logic [31:0] sbox_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic void expand_round_keys();
        logic [31:0] t;
        for (int i = 0; i < 8; i++)
            round_key[i] = i[0] ? key_word[i >> 1][31:0] : key_word[i >> 1][63:32];
        for (int i = 8; i < RK_WORDS; i++)
        begin
            t = round_key[i - 1];
            if (i % 8 == 0)
                t = sbox_word({t[23:0], t[31:24]}) ^ {8'h01 << (i / 8 - 1), 24'h0};
            else if (i % 8 == 4)
                t = sbox_word(t);
            round_key[i] = round_key[i - 8] ^ t;
        end
    endfunction

    function automatic logic [7:0] dbl(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [127:0] encrypt(input logic [127:0] x);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, all;
        logic [127:0] y;
        for (int i = 0; i < 16; i++)
            s[i] = x[127 - 8 * i -: 8];
        for (int rnd = 0; rnd <= NUM_ROUNDS; rnd++)
        begin
            if (rnd > 0)
            begin
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                        t[4 * c + r] = SBOX[s[4 * ((c + r) % 4) + r]];
                s = t;
            end
            if (rnd > 0 && rnd < NUM_ROUNDS)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0 = s[4 * c]; a1 = s[4 * c + 1]; a2 = s[4 * c + 2]; a3 = s[4 * c + 3];
                    all = a0 ^ a1 ^ a2 ^ a3;
                    s[4 * c]     = a0 ^ all ^ dbl(a0 ^ a1);
                    s[4 * c + 1] = a1 ^ all ^ dbl(a1 ^ a2);
                    s[4 * c + 2] = a2 ^ all ^ dbl(a2 ^ a3);
                    s[4 * c + 3] = a3 ^ all ^ dbl(a3 ^ a0);
                end
            end
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    s[4 * c + r] ^= round_key[rnd * 4 + c][31 - 8 * r -: 8];
        end
        for (int i = 0; i < 16; i++)
            y[127 - 8 * i -: 8] = s[i];
        return y;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [127:0] ct;
        ct_item_t exp_item;
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                key_word[i] = '0;
            iv_hi = '0;
            iv_lo = '0;
            chain_hi = '0;
            chain_lo = '0;
            keys_stale = 1'b1;
            ct_expected.delete();
            errors <= 0;
            pending <= 0;
            accepted <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[5:3])
                    REG_KEY_W0, REG_KEY_W1, REG_KEY_W2, REG_KEY_W3:
                    begin
                        key_word[paddr[4:3]] = pwdata;
                        keys_stale = 1'b1;
                    end
                    REG_IV_UPPER: iv_hi = pwdata;
                    REG_IV_LOWER: iv_lo = pwdata;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                if (keys_stale)
                    expand_round_keys();
                keys_stale = 1'b0;
                ct = encrypt({in_data.pt_upper, in_data.pt_lower} ^
                             (in_data.first_block ? {iv_hi, iv_lo} : {chain_hi, chain_lo}));
                {chain_hi, chain_lo} = ct;
                exp_item.ct_upper = ct[127:64];
                exp_item.ct_lower = ct[63:0];
                exp_item.ct_last = in_data.last_block;
                ct_expected.push_back(exp_item);
                accepted <= accepted + 1;
            end
            if (out_valid && !out_stall)
            begin
                if (ct_expected.size() == 0)
                begin
                    $display("%0t: unexpected ciphertext transfer, actual %h", $time, out_data);
                    errors <= errors + 1;
                end
                else
                begin
                    exp_item = ct_expected.pop_front();
                    if (out_data.ct_upper !== exp_item.ct_upper ||
                        out_data.ct_lower !== exp_item.ct_lower ||
                        out_data.ct_last !== exp_item.ct_last)
                    begin
                        $display({"%0t: ciphertext mismatch, expected %h_%h last %b, ",
                                  "actual %h_%h last %b"},
                                 $time, exp_item.ct_upper, exp_item.ct_lower, exp_item.ct_last,
                                 out_data.ct_upper, out_data.ct_lower, out_data.ct_last);
                        errors <= errors + 1;
                    end
                end
            end
            pending <= ct_expected.size();
        end
    end
endmodule

@@ verif/tb.sv @@
// testbench top for aes256_cbc_encrypt_top: clock, reset, apb writes and block stimulus
// depends on aes_cbc_pkg, aes256_cbc_encrypt_top and aes256_cbc_checker
`timescale 1ns / 1ps
module tb;
    import aes_cbc_pkg::*;

    localparam logic [2:0] REG_UNUSED = 3'd6;
    localparam int CYCLE_LIMIT = 2000000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    pt_item_t    in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    ct_item_t    out_data;
    int          errors, pending, accepted;
    int          tx_idle = 0;
    int          rx_idle = 0;
    int          cycles = 0;

    always #5 clk = ~clk;

    aes256_cbc_encrypt_top dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    aes256_cbc_checker chk (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .errors(errors), .pending(pending), .accepted(accepted)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver stalls; one long hold-off so the block backs up into its input
    initial
    begin
        int hold_left;
        bit held;
        hold_left = 0;
        held = 0;
        forever
        begin
            @(negedge clk);
            if (!held && accepted == 400)
            begin
                held = 1;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                out_stall = 1'b1;
                hold_left--;
            end
            else
                out_stall = ($urandom_range(99) < rx_idle);
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic [63:0] value);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0; paddr = {idx, 3'b000}; pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    task automatic load_key(input logic [63:0] k0, k1, k2, k3);
        reg_write(REG_KEY_W0, k0);
        reg_write(REG_KEY_W1, k1);
        reg_write(REG_KEY_W2, k2);
        reg_write(REG_KEY_W3, k3);
    endtask

    task automatic load_iv(input logic [63:0] hi, lo);
        reg_write(REG_IV_UPPER, hi);
        reg_write(REG_IV_LOWER, lo);
    endtask

    task automatic wait_idle();
        while (pending != 0 || in_valid)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic send_block(input logic [63:0] hi, lo, input logic first, last);
        int seen;
        while ($urandom_range(99) < tx_idle)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data = '{pt_upper: hi, pt_lower: lo, first_block: first, last_block: last};
        seen = accepted;
        do @(negedge clk); while (accepted == seen);
    endtask

    task automatic end_stream();
        in_valid = 1'b0;
        wait_idle();
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_message(input int len);
        logic first, last;
        for (int k = 0; k < len; k++)
        begin
            first = (k == 0);
            last = (k == len - 1);
            if ($urandom_range(9) == 0)
                {first, last} = 2'($urandom_range(3));
            send_block(rand64(), rand64(), first, last);
        end
    endtask

    task automatic random_phase(input int tx, input int rx, input int count);
        int sent;
        tx_idle = tx;
        rx_idle = rx;
        sent = 0;
        while (sent < count)
        begin
            int len;
            len = $urandom_range(1, 8);
            send_message(len);
            sent += len;
        end
        end_stream();
    endtask

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // no key or iv written: zero key, chaining from a zero value
        send_block('0, '0, 1'b0, 1'b0);
        send_block('1, '1, 1'b0, 1'b1);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1, 1'b0);
        end_stream();

        load_key('1, '1, '1, '1);
        load_iv('1, '1);
        reg_write(REG_UNUSED, '1);
        send_block('0, '0, 1'b1, 1'b0);
        send_block('1, '1, 1'b0, 1'b0);
        send_block(64'h8000000000000000, 64'h0000000000000001, 1'b0, 1'b1);
        // chaining continues past a last block
        send_block('0, '1, 1'b0, 1'b0);
        end_stream();

        // key change in the middle of a message
        load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                 64'h1011121314151617, 64'h18191a1b1c1d1e1f);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0, 1'b0);
        send_block('1, '0, 1'b1, 1'b1);
        end_stream();

        // iv change mid-message only applies at the next first block
        load_iv(64'h0123456789abcdef, 64'hfedcba9876543210);
        send_block('0, '0, 1'b0, 1'b0);
        send_block('0, '0, 1'b1, 1'b0);
        send_block('1, '1, 1'b1, 1'b1);
        end_stream();

        load_key('0, '0, '0, '0);
        load_iv('0, '0);
        random_phase(22, 86, 300);

        load_key(rand64(), rand64(), rand64(), rand64());
        load_iv(rand64(), rand64());
        random_phase(86, 22, 300);

        load_key(rand64(), rand64(), rand64(), rand64());
        load_iv(rand64(), rand64());
        random_phase(0, 0, 300);

        repeat (100) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
